// File: rtl/core/riffwav_pkg.sv
// shared constants and types for the riff/wave chunk parser
package riffwav_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] MIN_FILE_LEN = 32'd44;
	localparam logic [31:0] MIN_FMT_LEN  = 32'd16;
	localparam logic [31:0] WAVE_LAST_IDX = 32'd11;
	localparam logic [31:0] RIFF_LAST_IDX = 32'd3;
	localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;

	localparam int FMT_BYTES = 16;
	localparam int FMT_BITS  = FMT_BYTES * 8;

	typedef enum logic [2:0] {
		PH_FILE = 3'b001,
		PH_CHDR = 3'b010,
		PH_BODY = 3'b100
	} phase_t;

endpackage

// File: rtl/core/riff_wave_chunk_parser_unit.sv
// riff/wave byte stream parser: data payload out, verdict with format on the last byte
//
//   channel | direction | handshake          | fields
//   in      | input     | in_valid/in_ready   | in_byte, is_last
//   out     | output    | out_valid/out_ready | kind, payload_byte, chunk_first, chunk_end,
//           |           |                     | file_valid, format_tag, channel_count,
//           |           |                     | sample_rate, byte_rate, block_align,
//           |           |                     | sample_bits, data_size
//
// one byte per cycle: parser state updates in the cycle a byte is accepted and its
// results land in a single result stage, so a byte enters every cycle the stage drains
// a final data byte that also carries the verdict fills the stage with two results;
// the next byte then waits while both are delivered
// reset is asynchronous and leaves the parser at file offset zero; after the verdict the
// parser returns to that state by itself for the next file
// a stalled output only blocks input once the stage cannot take the next result
module riff_wave_chunk_parser_unit
	import riffwav_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic        chunk_first,
	output logic        chunk_end,
	output logic        file_valid,
	output logic [15:0] format_tag,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] byte_rate,
	output logic [15:0] block_align,
	output logic [15:0] sample_bits,
	output logic [31:0] data_size
);

	// parser state
	phase_t                phase_q;
	logic [31:0]           byte_count_q;
	logic                  header_ok_q;
	logic [31:0]           tag_shift_q;
	logic [31:0]           size_shift_q;
	logic [31:0]           bytes_left_q;
	logic                  pad_pending_q;
	logic [2:0]            hdr_idx_q;
	logic [FMT_BITS-1:0]   fmt_shadow_q;
	logic [FMT_BITS-1:0]   fmt_kept_q;
	logic                  fmt_seen_q;
	logic                  data_seen_q;
	logic [31:0]           last_data_size_q;

	// next state
	phase_t                phase_d;
	logic [31:0]           byte_count_d;
	logic                  header_ok_d;
	logic [31:0]           tag_shift_d;
	logic [31:0]           size_shift_d;
	logic [31:0]           bytes_left_d;
	logic                  pad_pending_d;
	logic [2:0]            hdr_idx_d;
	logic [FMT_BITS-1:0]   fmt_shadow_d;
	logic [FMT_BITS-1:0]   fmt_kept_d;
	logic                  fmt_seen_d;
	logic                  data_seen_d;
	logic [31:0]           last_data_size_d;

	logic                  gen_pay;
	logic                  pay_first;
	logic                  pay_end;
	logic                  finish;
	logic [31:0]           body_off;
	logic                  verdict_ok;

	// result stage
	logic                  pv_s1;
	logic                  vv_s1;
	logic [7:0]            pay_byte_s1;
	logic                  pay_first_s1;
	logic                  pay_end_s1;
	logic                  vd_ok_s1;
	logic [FMT_BITS-1:0]   vd_fmt_s1;
	logic [31:0]           vd_size_s1;

	logic                  in_acc;
	logic                  out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// stage takes a new request when empty or about to be empty
	assign in_ready  = !(pv_s1 || vv_s1) || (out_ready && !(pv_s1 && vv_s1));
	assign out_valid = pv_s1 || vv_s1;

	assign body_off = size_shift_q - bytes_left_q;

	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = (byte_count_q != COUNT_MAX) ? byte_count_q + 32'd1 : byte_count_q;
		header_ok_d      = header_ok_q;
		tag_shift_d      = tag_shift_q;
		size_shift_d     = size_shift_q;
		bytes_left_d     = bytes_left_q;
		pad_pending_d    = pad_pending_q;
		hdr_idx_d        = hdr_idx_q;
		fmt_shadow_d     = fmt_shadow_q;
		fmt_kept_d       = fmt_kept_q;
		fmt_seen_d       = fmt_seen_q;
		data_seen_d      = data_seen_q;
		last_data_size_d = last_data_size_q;
		gen_pay          = 1'b0;
		pay_first        = 1'b0;
		pay_end          = 1'b0;
		finish           = 1'b0;

		case (phase_q)
			PH_FILE: begin
				tag_shift_d = {in_byte, tag_shift_q[31:8]};
				if (byte_count_q == RIFF_LAST_IDX && tag_shift_d != TAG_RIFF) begin
					header_ok_d = 1'b0;
				end
				if (byte_count_q >= WAVE_LAST_IDX) begin
					if (tag_shift_d != TAG_WAVE) begin
						header_ok_d = 1'b0;
					end
					tag_shift_d = '0;
					hdr_idx_d   = '0;
					phase_d     = PH_CHDR;
				end
			end
			PH_BODY: begin
				if (tag_shift_q == TAG_FMT && body_off < MIN_FMT_LEN) begin
					for (int i = 0; i < FMT_BYTES; i++) begin
						if (body_off[3:0] == 4'(i)) begin
							fmt_shadow_d[i*8 +: 8] = in_byte;
						end
					end
				end
				if (tag_shift_q == TAG_DATA) begin
					gen_pay   = 1'b1;
					pay_first = (body_off == 32'd0);
					pay_end   = (bytes_left_q == 32'd1);
				end
				bytes_left_d = bytes_left_q - 32'd1;
				if (bytes_left_d == 32'd0) begin
					finish        = 1'b1;
					pad_pending_d = size_shift_q[0];
					hdr_idx_d     = '0;
					phase_d       = PH_CHDR;
				end
			end
			PH_CHDR: begin
				if (pad_pending_q) begin
					pad_pending_d = 1'b0;
				end else begin
					if (!hdr_idx_q[2]) begin
						tag_shift_d = {in_byte, tag_shift_q[31:8]};
					end else begin
						size_shift_d = {in_byte, size_shift_q[31:8]};
					end
					hdr_idx_d = hdr_idx_q + 3'd1;
					if (hdr_idx_q == 3'd7) begin
						if (size_shift_d == 32'd0) begin
							finish = 1'b1;
						end else begin
							bytes_left_d = size_shift_d;
							phase_d      = PH_BODY;
						end
					end
				end
			end
			default: begin
				phase_d = PH_FILE;
			end
		endcase

		// tag is stable here; size may have just shifted in
		if (finish) begin
			if (tag_shift_d == TAG_FMT && size_shift_d >= MIN_FMT_LEN) begin
				fmt_kept_d = fmt_shadow_d;
				fmt_seen_d = 1'b1;
			end else if (tag_shift_d == TAG_DATA) begin
				last_data_size_d = size_shift_d;
				data_seen_d      = 1'b1;
			end
		end
	end

	assign verdict_ok = (byte_count_d >= MIN_FILE_LEN) && header_ok_d && fmt_seen_d
		&& data_seen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_FILE;
			byte_count_q     <= '0;
			header_ok_q      <= 1'b1;
			tag_shift_q      <= '0;
			size_shift_q     <= '0;
			bytes_left_q     <= '0;
			pad_pending_q    <= 1'b0;
			hdr_idx_q        <= '0;
			fmt_shadow_q     <= '0;
			fmt_kept_q       <= '0;
			fmt_seen_q       <= 1'b0;
			data_seen_q      <= 1'b0;
			last_data_size_q <= '0;
		end else if (in_acc) begin
			if (is_last) begin
				// back to start of file
				phase_q          <= PH_FILE;
				byte_count_q     <= '0;
				header_ok_q      <= 1'b1;
				tag_shift_q      <= '0;
				size_shift_q     <= '0;
				bytes_left_q     <= '0;
				pad_pending_q    <= 1'b0;
				hdr_idx_q        <= '0;
				fmt_shadow_q     <= '0;
				fmt_kept_q       <= '0;
				fmt_seen_q       <= 1'b0;
				data_seen_q      <= 1'b0;
				last_data_size_q <= '0;
			end else begin
				phase_q          <= phase_d;
				byte_count_q     <= byte_count_d;
				header_ok_q      <= header_ok_d;
				tag_shift_q      <= tag_shift_d;
				size_shift_q     <= size_shift_d;
				bytes_left_q     <= bytes_left_d;
				pad_pending_q    <= pad_pending_d;
				hdr_idx_q        <= hdr_idx_d;
				fmt_shadow_q     <= fmt_shadow_d;
				fmt_kept_q       <= fmt_kept_d;
				fmt_seen_q       <= fmt_seen_d;
				data_seen_q      <= data_seen_d;
				last_data_size_q <= last_data_size_d;
			end
		end
	end

	// result stage control: payload goes out before the verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			vv_s1 <= 1'b0;
		end else if (in_acc) begin
			pv_s1 <= gen_pay;
			vv_s1 <= is_last;
		end else if (out_acc) begin
			if (pv_s1) begin
				pv_s1 <= 1'b0;
			end else begin
				vv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && gen_pay) begin
			pay_byte_s1  <= in_byte;
			pay_first_s1 <= pay_first;
			pay_end_s1   <= pay_end;
		end
		if (in_acc && is_last) begin
			vd_ok_s1   <= verdict_ok;
			vd_fmt_s1  <= fmt_kept_d;
			vd_size_s1 <= last_data_size_d;
		end
	end

	assign kind          = !pv_s1;
	assign payload_byte  = pv_s1 ? pay_byte_s1 : 8'd0;
	assign chunk_first   = pv_s1 && pay_first_s1;
	assign chunk_end     = pv_s1 && pay_end_s1;
	assign file_valid    = !pv_s1 && vd_ok_s1;
	assign format_tag    = pv_s1 ? 16'd0 : vd_fmt_s1[15:0];
	assign channel_count = pv_s1 ? 16'd0 : vd_fmt_s1[31:16];
	assign sample_rate   = pv_s1 ? 32'd0 : vd_fmt_s1[63:32];
	assign byte_rate     = pv_s1 ? 32'd0 : vd_fmt_s1[95:64];
	assign block_align   = pv_s1 ? 16'd0 : vd_fmt_s1[111:96];
	assign sample_bits   = pv_s1 ? 16'd0 : vd_fmt_s1[127:112];
	assign data_size     = pv_s1 ? 32'd0 : vd_size_s1;

`ifndef ASSERT_OFF
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && (!out_ready || (pv_s1 && vv_s1))))
		else $error("input stalled while result stage can drain");

	a_last_gives_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_last) |=> (vv_s1 && out_valid))
		else $error("last byte did not produce a verdict");

	a_pair_drains_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(pv_s1 && vv_s1 && out_ready) |=> (!pv_s1 && vv_s1 && kind))
		else $error("verdict lost or payload repeated");

	a_restart_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && is_last) |=> (phase_q == PH_FILE && byte_count_q == 32'd0))
		else $error("parser did not restart after last byte");
`endif

endmodule
